### rtl/quaternion_to_euler_angles_core_assert.svh
// Assertion macros, compiled out when NO_ASSERTIONS is defined
`ifndef QUATERNION_TO_EULER_ANGLES_CORE_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define QTE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("qte assertion failed");
`define QTE_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("qte assertion failed during or after reset");
`else
`define QTE_ASSERT(lbl, prop)
`define QTE_ASSERT_RST(lbl, prop)
`endif

`endif

### rtl/qte_pkg.sv
package qte_pkg;

  localparam int IN_W     = 16;
  localparam int PROD_W   = 32;
  localparam int TERM_W   = 36;
  localparam int CORDIC_W = TERM_W + 2;
  localparam int ANG_W    = 16;
  localparam int SQ_W     = 56;
  localparam int RAD_W    = 57;
  localparam int ROOT_W   = 29;
  localparam int SQRT_W   = 58;
  localparam int SQRT_STEPS = 29;
  localparam int ATAN_LEN = 24;

  localparam logic signed [TERM_W-1:0] ONE_Q28 = TERM_W'(64'sd1 <<< 28);
  localparam logic signed [ANG_W-1:0]  PITCH_MAX = 16'sd16384;
  localparam logic signed [ANG_W-1:0]  PITCH_MIN = -16'sd16384;

  // atan(2^-i), 2^31 = pi
  localparam logic [31:0] ATAN_MASTER [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [TERM_W-1:0] sr;
    logic signed [TERM_W-1:0] cr;
    logic signed [TERM_W-1:0] sp;
    logic signed [TERM_W-1:0] sy;
    logic signed [TERM_W-1:0] cy;
    logic                     gimbal;
  } side_t;

  // table entry rounded to nearest at angle width aw (aw <= 24)
  function automatic logic [31:0] atan_entry(input int i, input int aw);
    logic [32:0] t;
    int          sh;
    sh = 32 - aw;
    t  = {1'b0, ATAN_MASTER[i]} + (33'd1 << (sh - 1));
    return 32'(t >> sh);
  endfunction

endpackage

### rtl/quaternion_to_euler_angles_core.sv
// Quaternion to ZYX Euler angles, fully pipelined.
// Stages between the start edge and valid_o:
// 5 product/term stages, 29 square-root stages, CORDIC_STEPS + 2 CORDIC stages, 1 output.
// Throughput: one item per cycle; busy_o stays low, the receiver cannot stall.
// Reset clears only the valid bits; payload registers are not reset.
`include "quaternion_to_euler_angles_core_assert.svh"

module quaternion_to_euler_angles_core #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_WIDTH  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  output logic               valid_o,
  output logic signed [15:0] roll_angle_o,
  output logic signed [15:0] pitch_angle_o,
  output logic signed [15:0] yaw_angle_o,
  output logic               gimbal_clamped_o
);

  localparam int TW = qte_pkg::TERM_W;
  localparam int PW = qte_pkg::PROD_W;
  localparam int LATENCY = CORDIC_STEPS + 5 + qte_pkg::SQRT_STEPS + 3;

  assign busy_o = 1'b0;

  // stage 1: input capture
  logic                 v1_q;
  logic signed [15:0]   w_q, x_q, y_q, z_q;

  // stage 2: products
  logic                 v2_q;
  logic signed [PW-1:0] p_wx_q, p_yz_q, p_xx_q, p_yy_q, p_wy_q;
  logic signed [PW-1:0] p_zx_q, p_wz_q, p_xy_q, p_zz_q;

  // stage 3: terms
  logic                 v3_q;
  qte_pkg::side_t       t3_q;

  // stage 4: pitch sine squared
  logic                 v4_q;
  qte_pkg::side_t       t4_q, t4_d;
  logic [qte_pkg::SQ_W-1:0] sq_q;

  // stage 5: radicand
  logic                 v5_q;
  qte_pkg::side_t       t5_q;
  logic [qte_pkg::RAD_W-1:0] rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  logic signed [TW-1:0]  sp3;
  logic signed [28:0]    sp_small;
  logic signed [57:0]    sp_prod;
  logic                  gimbal3;

  assign sp3      = t3_q.sp;
  assign gimbal3  = (sp3 >= qte_pkg::ONE_Q28) || (sp3 <= -qte_pkg::ONE_Q28);
  assign sp_small = sp3[28:0];
  assign sp_prod  = sp_small * sp_small;

  always_comb begin
    t4_d        = t3_q;
    t4_d.gimbal = gimbal3;
  end

  always_ff @(posedge clk_i) begin
    w_q <= quat_w_i;
    x_q <= quat_x_i;
    y_q <= quat_y_i;
    z_q <= quat_z_i;

    p_wx_q <= w_q * x_q;
    p_yz_q <= y_q * z_q;
    p_xx_q <= x_q * x_q;
    p_yy_q <= y_q * y_q;
    p_wy_q <= w_q * y_q;
    p_zx_q <= z_q * x_q;
    p_wz_q <= w_q * z_q;
    p_xy_q <= x_q * y_q;
    p_zz_q <= z_q * z_q;

    t3_q.sr     <= (TW'(p_wx_q) + TW'(p_yz_q)) <<< 1;
    t3_q.cr     <= qte_pkg::ONE_Q28 - ((TW'(p_xx_q) + TW'(p_yy_q)) <<< 1);
    t3_q.sp     <= (TW'(p_wy_q) - TW'(p_zx_q)) <<< 1;
    t3_q.sy     <= (TW'(p_wz_q) + TW'(p_xy_q)) <<< 1;
    t3_q.cy     <= qte_pkg::ONE_Q28 - ((TW'(p_yy_q) + TW'(p_zz_q)) <<< 1);
    t3_q.gimbal <= 1'b0;

    t4_q        <= t4_d;
    sq_q        <= gimbal3 ? '0 : sp_prod[qte_pkg::SQ_W-1:0];

    t5_q  <= t4_q;
    rad_q <= (qte_pkg::RAD_W'(1) << qte_pkg::SQ_W) - qte_pkg::RAD_W'(sq_q);
  end

  // square root of 1 - sp^2
  localparam int SIDE_W = $bits(qte_pkg::side_t);
  logic                       sq_v;
  logic [qte_pkg::ROOT_W-1:0] root;
  logic [SIDE_W-1:0]          side_vec;
  qte_pkg::side_t             side;

  qte_isqrt #(
    .TAG_W (SIDE_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v5_q),
    .rad_i   (rad_q),
    .tag_i   (t5_q),
    .valid_o (sq_v),
    .root_o  (root),
    .tag_o   (side_vec)
  );

  assign side = side_vec;

  logic signed [TW-1:0] cp;
  assign cp = $signed({{(TW - qte_pkg::ROOT_W){1'b0}}, root});

  logic                     roll_v;
  logic signed [15:0]       roll_ang, pitch_ang, yaw_ang;
  logic [1:0]               pitch_tag;

  qte_cordic #(
    .STEPS (CORDIC_STEPS),
    .AW    (ANGLE_WIDTH),
    .TAG_W (1)
  ) u_cordic_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_v),
    .y_i     (side.sr),
    .x_i     (side.cr),
    .tag_i   (1'b0),
    .valid_o (roll_v),
    .angle_o (roll_ang),
    .tag_o   ()
  );

  qte_cordic #(
    .STEPS (CORDIC_STEPS),
    .AW    (ANGLE_WIDTH),
    .TAG_W (2)
  ) u_cordic_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_v),
    .y_i     (side.sp),
    .x_i     (cp),
    .tag_i   ({side.gimbal, side.sp[TW-1]}),
    .valid_o (),
    .angle_o (pitch_ang),
    .tag_o   (pitch_tag)
  );

  qte_cordic #(
    .STEPS (CORDIC_STEPS),
    .AW    (ANGLE_WIDTH),
    .TAG_W (1)
  ) u_cordic_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_v),
    .y_i     (side.sy),
    .x_i     (side.cy),
    .tag_i   (1'b0),
    .valid_o (),
    .angle_o (yaw_ang),
    .tag_o   ()
  );

  // output register: pitch clamp / saturation
  logic               valid_q, gimbal_q;
  logic signed [15:0] roll_q, pitch_q, yaw_q, pitch_d;

  always_comb begin
    if (pitch_tag[1]) begin
      pitch_d = pitch_tag[0] ? qte_pkg::PITCH_MIN : qte_pkg::PITCH_MAX;
    end else if (pitch_ang > qte_pkg::PITCH_MAX) begin
      pitch_d = qte_pkg::PITCH_MAX;
    end else if (pitch_ang < qte_pkg::PITCH_MIN) begin
      pitch_d = qte_pkg::PITCH_MIN;
    end else begin
      pitch_d = pitch_ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= roll_v;
    end
  end

  always_ff @(posedge clk_i) begin
    roll_q   <= roll_ang;
    pitch_q  <= pitch_d;
    yaw_q    <= yaw_ang;
    gimbal_q <= pitch_tag[1];
  end

  assign valid_o          = valid_q;
  assign roll_angle_o     = roll_q;
  assign pitch_angle_o    = pitch_q;
  assign yaw_angle_o      = yaw_q;
  assign gimbal_clamped_o = gimbal_q;

  `QTE_ASSERT(a_latency, start_i && !busy_o |-> ##LATENCY valid_o)
  `QTE_ASSERT(a_pitch_range, valid_o |-> (pitch_angle_o <= qte_pkg::PITCH_MAX) && (pitch_angle_o >= qte_pkg::PITCH_MIN))
  `QTE_ASSERT(a_gimbal_pitch, valid_o && gimbal_clamped_o |-> (pitch_angle_o == qte_pkg::PITCH_MAX) || (pitch_angle_o == qte_pkg::PITCH_MIN))
  `QTE_ASSERT_RST(a_reset_quiet, !rst_ni |=> !valid_o)

endmodule

### rtl/qte_isqrt.sv
module qte_isqrt #(
  parameter int TAG_W = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [qte_pkg::RAD_W-1:0]     rad_i,
  input  logic [TAG_W-1:0]              tag_i,
  output logic                          valid_o,
  output logic [qte_pkg::ROOT_W-1:0]    root_o,
  output logic [TAG_W-1:0]              tag_o
);

  localparam int N  = qte_pkg::SQRT_STEPS;
  localparam int SW = qte_pkg::SQRT_W;

  logic          v_q   [N];
  logic [SW-1:0] rem_q [N];
  logic [SW-1:0] r_q   [N];
  logic [TAG_W-1:0] tag_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [SW-1:0] BIT = SW'(1) << (2 * (N - 1 - k));
    logic          v_in;
    logic [SW-1:0] rem_in, r_in, t, rem_d, r_d;
    logic [TAG_W-1:0] tag_in;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = SW'(rad_i);
      assign r_in   = '0;
      assign tag_in = tag_i;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign rem_in = rem_q[k-1];
      assign r_in   = r_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    always_comb begin
      t = r_in + BIT;
      if (rem_in >= t) begin
        rem_d = rem_in - t;
        r_d   = (r_in >> 1) + BIT;
      end else begin
        rem_d = rem_in;
        r_d   = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_d;
      r_q[k]   <= r_d;
      tag_q[k] <= tag_in;
    end
  end

  assign valid_o = v_q[N-1];
  assign root_o  = r_q[N-1][qte_pkg::ROOT_W-1:0];
  assign tag_o   = tag_q[N-1];

endmodule

### rtl/qte_cordic.sv
module qte_cordic #(
  parameter int STEPS = 16,
  parameter int AW    = 16,
  parameter int TAG_W = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [qte_pkg::TERM_W-1:0] y_i,
  input  logic signed [qte_pkg::TERM_W-1:0] x_i,
  input  logic [TAG_W-1:0]                  tag_i,
  output logic                              valid_o,
  output logic signed [qte_pkg::ANG_W-1:0]  angle_o,
  output logic [TAG_W-1:0]                  tag_o
);

  localparam int DW = qte_pkg::CORDIC_W;
  localparam logic signed [AW-1:0] QUARTER = AW'(1) << (AW - 2);

  logic                 v_q    [STEPS+1];
  logic signed [DW-1:0] x_q    [STEPS+1];
  logic signed [DW-1:0] y_q    [STEPS+1];
  logic signed [AW-1:0] z_q    [STEPS+1];
  logic                 zero_q [STEPS+1];
  logic [TAG_W-1:0]     tag_q  [STEPS+1];

  // quadrant fold into the right half-plane
  logic signed [DW-1:0] xe, ye, x0_d, y0_d;
  logic signed [AW-1:0] z0_d;

  always_comb begin
    xe = DW'(x_i);
    ye = DW'(y_i);
    x0_d = xe;
    y0_d = ye;
    z0_d = '0;
    if (xe < 0) begin
      if (ye >= 0) begin
        x0_d = ye;
        y0_d = -xe;
        z0_d = QUARTER;
      end else begin
        x0_d = -ye;
        y0_d = xe;
        z0_d = -QUARTER;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= x0_d;
    y_q[0]    <= y0_d;
    z_q[0]    <= z0_d;
    zero_q[0] <= (x_i == '0) && (y_i == '0);
    tag_q[0]  <= tag_i;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic [31:0] AFULL = qte_pkg::atan_entry(i, AW);
    localparam logic signed [AW-1:0] ANG = AFULL[AW-1:0];
    logic signed [DW-1:0] dx, dy;

    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (y_q[i] >= 0) begin
        x_q[i+1] <= x_q[i] + dx;
        y_q[i+1] <= y_q[i] - dy;
        z_q[i+1] <= z_q[i] + ANG;
      end else begin
        x_q[i+1] <= x_q[i] - dx;
        y_q[i+1] <= y_q[i] + dy;
        z_q[i+1] <= z_q[i] - ANG;
      end
      zero_q[i+1] <= zero_q[i];
      tag_q[i+1]  <= tag_q[i];
    end
  end

  // accumulator to 16-bit binary angle
  logic [qte_pkg::ANG_W-1:0] ang16;

  if (AW > qte_pkg::ANG_W) begin : g_round
    localparam int SH = AW - qte_pkg::ANG_W;
    logic [AW-1:0] zr;
    assign zr    = z_q[STEPS] + (AW'(1) << (SH - 1));
    assign ang16 = zr[AW-1:SH];
  end else if (AW == qte_pkg::ANG_W) begin : g_same
    assign ang16 = z_q[STEPS];
  end else begin : g_widen
    assign ang16 = {z_q[STEPS], {(qte_pkg::ANG_W - AW){1'b0}}};
  end

  logic                           v_out_q;
  logic signed [qte_pkg::ANG_W-1:0] ang_q;
  logic [TAG_W-1:0]               tag_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_out_q <= 1'b0;
    end else begin
      v_out_q <= v_q[STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    ang_q     <= zero_q[STEPS] ? '0 : ang16;
    tag_out_q <= tag_q[STEPS];
  end

  assign valid_o = v_out_q;
  assign angle_o = ang_q;
  assign tag_o   = tag_out_q;

endmodule

### sim/quaternion_to_euler_angles_checker.sv
module quaternion_to_euler_angles_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic               valid_i,
  input  logic signed [15:0] roll_angle_i,
  input  logic signed [15:0] pitch_angle_i,
  input  logic signed [15:0] yaw_angle_i,
  input  logic               gimbal_clamped_i,
  output int                 mismatch_count_o,
  output int                 angles_pending_o
);

  localparam int STEPS   = 16;
  localparam int ANGLE_W = 16;
  localparam longint UNIT = longint'(1) << 28;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic               gimbal;
  } euler_t;

  euler_t euler_q[$];

  function automatic longint atan_step(input int i);
    longint unsigned t;
    int sh;
    sh = 32 - ANGLE_W;
    t  = qte_pkg::ATAN_MASTER[i];
    if (sh > 0) t = (t + (longint'(1) << (sh - 1))) >> sh;
    return longint'(t);
  endfunction

  function automatic longint vector_angle(input longint sv, input longint cv);
    longint ys, xs, acc, t, dx, dy;
    ys  = sv;
    xs  = cv;
    acc = 0;
    if (xs == 0 && ys == 0) return 0;
    if (xs < 0) begin
      t = xs;
      if (ys >= 0) begin
        xs = ys; ys = -t; acc = longint'(1) << (ANGLE_W - 2);
      end else begin
        xs = -ys; ys = t; acc = -(longint'(1) << (ANGLE_W - 2));
      end
    end
    for (int i = 0; i < STEPS && i < qte_pkg::ATAN_LEN; i++) begin
      dx = ys >>> i;
      dy = xs >>> i;
      if (ys >= 0) begin
        xs += dx; ys -= dy; acc += atan_step(i);
      end else begin
        xs -= dx; ys += dy; acc -= atan_step(i);
      end
    end
    return acc;
  endfunction

  function automatic logic [15:0] bam16(input longint a);
    longint unsigned u;
    u = longint'(a);
    if (ANGLE_W > 16) u = (u + (longint'(1) << (ANGLE_W - 17))) >> (ANGLE_W - 16);
    else u = u << (16 - ANGLE_W);
    return u[15:0];
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic euler_t predict_euler(input logic signed [15:0] qw, qx, qy, qz);
    longint w, x, y, z, sr, cr, sp, sy, cy, p;
    longint unsigned c;
    euler_t e;
    w  = qw; x = qx; y = qy; z = qz;
    sr = 2 * (w * x + y * z);
    cr = UNIT - 2 * (x * x + y * y);
    sp = 2 * (w * y - z * x);
    sy = 2 * (w * z + x * y);
    cy = UNIT - 2 * (y * y + z * z);
    e.gimbal = 1'b0;
    if (sp >= UNIT || sp <= -UNIT) begin
      e.gimbal = 1'b1;
      e.pitch  = (sp > 0) ? qte_pkg::PITCH_MAX : qte_pkg::PITCH_MIN;
    end else begin
      c = floor_sqrt((longint'(1) << 56) - longint'(sp * sp));
      p = longint'($signed(bam16(vector_angle(sp, longint'(c)))));
      if (p > 16384) p = 16384;
      if (p < -16384) p = -16384;
      e.pitch = p[15:0];
    end
    e.roll = bam16(vector_angle(sr, cr));
    e.yaw  = bam16(vector_angle(sy, cy));
    return e;
  endfunction

  always @(posedge clk_i) begin
    euler_t got, want;
    if (!rst_ni) begin
      mismatch_count_o = 0;
    end else begin
      if (start_i && !busy_i)
        euler_q.push_back(predict_euler(quat_w_i, quat_x_i, quat_y_i, quat_z_i));
      if (valid_i) begin
        got = '{roll_angle_i, pitch_angle_i, yaw_angle_i, gimbal_clamped_i};
        if (euler_q.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("unexpected result: roll %0d pitch %0d yaw %0d gimbal %0b",
                     got.roll, got.pitch, got.yaw, got.gimbal);
        end else begin
          want = euler_q.pop_front();
          if (got !== want) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10)
              $display("mismatch: exp roll %0d pitch %0d yaw %0d gimbal %0b, ",
                       want.roll, want.pitch, want.yaw, want.gimbal,
                       "got roll %0d pitch %0d yaw %0d gimbal %0b",
                       got.roll, got.pitch, got.yaw, got.gimbal);
          end
        end
      end
    end
    angles_pending_o = euler_q.size();
  end

endmodule

### sim/quaternion_to_euler_angles_core_test.sv
module quaternion_to_euler_angles_core_test;

  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN      = 60;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic signed [15:0] quat_w_i = '0;
  logic signed [15:0] quat_x_i = '0;
  logic signed [15:0] quat_y_i = '0;
  logic signed [15:0] quat_z_i = '0;
  logic               valid_o;
  logic signed [15:0] roll_angle_o, pitch_angle_o, yaw_angle_o;
  logic               gimbal_clamped_o;
  int                 mismatch_count, angles_pending;
  int                 idle_cycles = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  quaternion_to_euler_angles_core dut (.*);

  quaternion_to_euler_angles_checker checker_i (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o),
    .quat_w_i, .quat_x_i, .quat_y_i, .quat_z_i,
    .valid_i(valid_o), .roll_angle_i(roll_angle_o), .pitch_angle_i(pitch_angle_o),
    .yaw_angle_i(yaw_angle_o), .gimbal_clamped_i(gimbal_clamped_o),
    .mismatch_count_o(mismatch_count), .angles_pending_o(angles_pending)
  );

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // drive one item, start held through consecutive items
  task automatic send_quat(input logic signed [15:0] w, x, y, z);
    @(negedge clk_i);
    start_i  <= 1'b1;
    quat_w_i <= w;
    quat_x_i <= x;
    quat_y_i <= y;
    quat_z_i <= z;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic idle_gap(input int n);
    @(negedge clk_i);
    start_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_part();
    return 16'(int'($urandom_range(32768)) - 16384);
  endfunction

  task automatic send_random();
    logic signed [15:0] a, b, c, d;
    int kind;
    kind = $urandom_range(9);
    a = rand_part(); b = rand_part(); c = rand_part(); d = rand_part();
    case (kind)
      0, 1: begin
        // near gimbal lock: w close to +-y, x equal to +z or -z
        c = ($urandom_range(1)) ? a + 16'($urandom_range(6)) - 16'sd3
                                : -a + 16'($urandom_range(6)) - 16'sd3;
        d = 16'(int'($urandom_range(200)) - 100);
        b = ($urandom_range(1)) ? d : -d;
      end
      2, 3, 4: begin
        // components halved to at most half a unit each
        a = a >>> 1; b = b >>> 1; c = c >>> 1; d = d >>> 1;
      end
      5: begin
        b = 16'sd0; d = 16'sd0;
      end
      default: ;
    endcase
    if (a > 16384) a = 16384;
    if (a < -16384) a = -16384;
    if (c > 16384) c = 16384;
    if (c < -16384) c = -16384;
    send_quat(a, b, c, d);
  endtask

  initial begin
    int burst;
    int sent;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_quat(16384, 0, 0, 0);
    send_quat(-16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, -16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 0, 0, 16384);
    send_quat(0, 0, 0, -16384);
    send_quat(0, 0, 0, 0);
    send_quat(0, 8192, 8192, 0);
    send_quat(16384, 16384, 16384, 16384);
    send_quat(-16384, -16384, -16384, -16384);
    send_quat(16384, 0, 16384, 0);
    send_quat(16384, 0, -16384, 0);
    send_quat(0, 16384, 0, -16384);
    send_quat(11585, 0, 11585, 0);
    send_quat(11585, 0, -11585, 0);
    send_quat(8192, 8192, 8192, 8192);
    send_quat(8192, -8192, 8192, 8192);
    send_quat(1, 16384, -1, 0);
    send_quat(-1, 16384, 1, 0);
    send_quat(0, 16384, 0, 1);
    send_quat(0, 16384, 0, -1);

    sent = 0;
    while (sent < 1100) begin
      burst = ($urandom_range(4) == 0) ? 60 : $urandom_range(1, 20);
      for (int i = 0; i < burst; i++) send_random();
      sent += burst;
      if (sent >= 500 && sent < 500 + burst) begin
        idle_gap(0);
        wait (angles_pending == 0);
      end else if ($urandom_range(3) != 0) begin
        idle_gap($urandom_range(8));
      end
    end
    idle_gap(0);

    wait (angles_pending == 0);
    repeat (DRAIN) @(posedge clk_i);
    if (mismatch_count == 0 && angles_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
